/* hw/rtl/cdll_pkg.sv */
// ============================================================================
// cdll_pkg: shared types and constants for the cursor linked list
// Operation codes, decoded command word, status codes, engine states.
// ============================================================================
package cdll_pkg;

    localparam int unsigned PoolDepthDefault  = 256;
    localparam int unsigned ValueWidthDefault = 32;
    localparam int unsigned FuncW             = 4;
    localparam int unsigned DataW             = 32;
    localparam int unsigned LenW              = 9;

    typedef enum logic [3:0] {
        OP_CLEAR      = 4'd0,
        OP_PREPEND    = 4'd1,
        OP_APPEND     = 4'd2,
        OP_INS_BEFORE = 4'd3,
        OP_INS_AFTER  = 4'd4,
        OP_DEL_FRONT  = 4'd5,
        OP_DEL_BACK   = 4'd6,
        OP_DEL_CURSOR = 4'd7,
        OP_MV_FRONT   = 4'd8,
        OP_MV_BACK    = 4'd9,
        OP_MV_PREV    = 4'd10,
        OP_MV_NEXT    = 4'd11,
        OP_READ       = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEEDCUR = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        EX_IDLE,
        EX_DECIDE,
        EX_RD1,
        EX_WAIT1,
        EX_WR1,
        EX_WR2,
        EX_WR3,
        EX_RDOUT,
        EX_WAITOUT,
        EX_REPORT
    } ex_state_t;

    // command word from front to back
    typedef struct packed {
        op_t                func;
        logic [DataW-1:0]   value;
    } cmd_t;

endpackage

/* hw/rtl/cdll_ram.sv */
// ============================================================================
// cdll_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ============================================================================
module cdll_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/cdll_front.sv */
// ============================================================================
// cdll_front: input stage and command queue
// Accepts words, masks the op code, and holds them in a two-entry queue.
// ============================================================================
module cdll_front
    import cdll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [FuncW-1:0] func,
    input  logic [DataW-1:0] value_in,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  logic             cmd_take
);

    cmd_t       q_reg [2];
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       do_push, do_pop;

    // unused codes behave as a read
    always_comb
    begin
        in_cmd.value = value_in;
        if (func > FuncW'(OP_READ))
        begin
            in_cmd.func = OP_READ;
        end
        else
        begin
            in_cmd.func = op_t'(func);
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        rd_next  = do_pop ? !rd_reg : rd_reg;
        wr_next  = do_push ? !wr_reg : wr_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push not counted");
    a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> rd_reg == wr_reg)
        else $error("pointer mismatch");
`endif

endmodule

/* hw/rtl/cdll_back.sv */
// ============================================================================
// cdll_back: list execution engine
// Runs one command through the link RAMs and produces one result word.
// ============================================================================
module cdll_back
    import cdll_pkg::*;
#(
    parameter int unsigned POOL_DEPTH  = PoolDepthDefault,
    parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_take,
    output logic             res_valid,
    input  logic             res_take,
    output logic [1:0]       status,
    output logic [LenW-1:0]  list_length,
    output logic [LenW-1:0]  cursor_pos,
    output logic [DataW-1:0] cursor_value,
    output logic [DataW-1:0] front_value,
    output logic [DataW-1:0] back_value
);

    localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

    ex_state_t st_reg, st_next;

    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next, cur_reg, cur_next;
    logic          cval_reg, cval_next;
    logic [CW-1:0] cidx_reg, cidx_next, cnt_reg, cnt_next;
    logic [AW-1:0] fhead_reg, fhead_next;
    logic [CW-1:0] fcnt_reg, fcnt_next, nu_reg, nu_next;

    cmd_t          c_reg, c_next;
    status_t       sts_reg, sts_next;
    logic [AW-1:0] n_reg, n_next;          // node allocated or removed, or cursor node for moves
    logic [AW-1:0] p_reg, p_next;          // neighbor prev link
    logic [AW-1:0] q_reg, q_next;          // neighbor next link
    logic [1:0]    rdo_reg, rdo_next;      // output read phase

    logic          ob_full_reg, ob_full_next;
    logic [1:0]    ob_sts_reg;
    logic [CW-1:0] ob_len_reg;
    logic [LenW-1:0] ob_pos_reg;
    logic [DataW-1:0] ob_cv_reg, ob_fv_reg, ob_bv_reg;
    logic [DataW-1:0] cv_reg, fv_reg, bv_reg;
    logic          ob_load;

    // RAM ports
    logic                   nx_we, pv_we, vl_we;
    logic [AW-1:0]          nx_wa, pv_wa, vl_wa, nx_ra, pv_ra, vl_ra;
    logic [AW-1:0]          nx_wd, pv_wd, nx_rd, pv_rd;
    logic [VALUE_WIDTH-1:0] vl_wd, vl_rd;
    logic [DataW-1:0]       vl_ext;

    logic full_pool, empty_list;
    logic [AW-1:0] alloc_n;

    cdll_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    cdll_ram #(.WIDTH(AW), .DEPTH(POOL_DEPTH)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
    cdll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_val_ram (
        .clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));

    // stored value sign-extended or cut back to the port width
    assign vl_ext = DataW'($signed(vl_rd));

    assign full_pool  = (cnt_reg >= CW'(POOL_DEPTH));
    assign empty_list = (cnt_reg == '0);
    assign alloc_n    = (fcnt_reg != '0) ? fhead_reg : nu_reg[AW-1:0];
    assign cmd_take   = (st_reg == EX_IDLE) && cmd_valid;

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            EX_IDLE:    if (cmd_valid) st_next = EX_DECIDE;
            EX_DECIDE:
            begin
                if (sts_next != ST_OK)
                begin
                    st_next = EX_RDOUT;
                end
                else
                begin
                    case (c_reg.func)
                        OP_CLEAR, OP_MV_FRONT, OP_MV_BACK, OP_READ:
                            st_next = EX_RDOUT;
                        default:
                            st_next = EX_RD1;
                    endcase
                end
            end
            EX_RD1:     st_next = EX_WAIT1;
            EX_WAIT1:   st_next = EX_WR1;
            EX_WR1:     st_next = EX_WR2;
            EX_WR2:     st_next = EX_WR3;
            EX_WR3:     st_next = EX_RDOUT;
            EX_RDOUT:   st_next = EX_WAITOUT;
            EX_WAITOUT: st_next = (rdo_reg == 2'd2) ? EX_REPORT : EX_RDOUT;
            EX_REPORT:  if (!ob_full_reg || res_take) st_next = EX_IDLE;
            default:    st_next = EX_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next = head_reg;  tail_next = tail_reg;  cur_next = cur_reg;
        cval_next = cval_reg;  cidx_next = cidx_reg;  cnt_next = cnt_reg;
        fhead_next = fhead_reg; fcnt_next = fcnt_reg; nu_next = nu_reg;
        c_next = c_reg; sts_next = sts_reg; n_next = n_reg;
        p_next = p_reg; q_next = q_reg; rdo_next = rdo_reg;
        nx_we = 1'b0; pv_we = 1'b0; vl_we = 1'b0;
        nx_wa = n_reg; pv_wa = n_reg; vl_wa = n_reg;
        nx_wd = '0; pv_wd = '0; vl_wd = VALUE_WIDTH'($signed(c_reg.value));
        nx_ra = n_reg; pv_ra = n_reg; vl_ra = head_reg;
        ob_load = 1'b0;

        case (st_reg)
            EX_IDLE:
            begin
                if (cmd_valid)
                begin
                    c_next   = cmd;
                    sts_next = ST_OK;
                    rdo_next = 2'd0;
                end
            end
            EX_DECIDE:
            begin
                case (c_reg.func)
                    OP_CLEAR:
                    begin
                        head_next = '0; tail_next = '0; cur_next = '0;
                        cval_next = 1'b0; cidx_next = '0; cnt_next = '0;
                        fhead_next = '0; fcnt_next = '0; nu_next = '0;
                    end
                    OP_PREPEND, OP_APPEND:
                    begin
                        if (full_pool) sts_next = ST_FULL;
                        else n_next = alloc_n;
                    end
                    OP_INS_BEFORE, OP_INS_AFTER:
                    begin
                        if (!cval_reg || empty_list) sts_next = ST_NEEDCUR;
                        else if (full_pool) sts_next = ST_FULL;
                        else n_next = alloc_n;
                    end
                    OP_DEL_FRONT:
                    begin
                        if (empty_list) sts_next = ST_NEEDCUR;
                        else n_next = head_reg;
                    end
                    OP_DEL_BACK:
                    begin
                        if (empty_list) sts_next = ST_NEEDCUR;
                        else n_next = tail_reg;
                    end
                    OP_DEL_CURSOR:
                    begin
                        if (!cval_reg || empty_list) sts_next = ST_NEEDCUR;
                        else n_next = cur_reg;
                    end
                    OP_MV_FRONT:
                    begin
                        if (!empty_list)
                        begin
                            cur_next = head_reg; cidx_next = '0; cval_next = 1'b1;
                        end
                    end
                    OP_MV_BACK:
                    begin
                        if (!empty_list)
                        begin
                            cur_next = tail_reg; cidx_next = cnt_reg - 1'b1;
                            cval_next = 1'b1;
                        end
                    end
                    OP_MV_PREV, OP_MV_NEXT:
                    begin
                        n_next = cur_reg;
                    end
                    default: ;
                endcase
            end
            EX_RD1:
            begin
                // links of the target node, or the anchor links for inserts
                nx_ra = n_reg;
                pv_ra = n_reg;
                case (c_reg.func)
                    OP_PREPEND:    begin nx_ra = n_reg; pv_ra = head_reg; end
                    OP_APPEND:     begin nx_ra = tail_reg; pv_ra = n_reg; end
                    OP_INS_BEFORE: begin nx_ra = n_reg; pv_ra = cur_reg; end
                    OP_INS_AFTER:  begin nx_ra = cur_reg; pv_ra = n_reg; end
                    default: ;
                endcase
            end
            EX_WAIT1:
            begin
                // capture first read; next RAM now reads the free link of n
                p_next = pv_rd;
                q_next = nx_rd;
            end
            EX_WR1:
            begin
                case (c_reg.func)
                    OP_PREPEND, OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER:
                    begin
                        vl_we = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (fcnt_reg != '0)
                        begin
                            fcnt_next  = fcnt_reg - 1'b1;
                            fhead_next = nx_rd;
                        end
                        else
                        begin
                            nu_next = nu_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            EX_WR2:
            begin
                case (c_reg.func)
                    OP_PREPEND, OP_APPEND:
                    begin
                        if (cnt_reg == CW'(1))
                        begin
                            head_next = n_reg; tail_next = n_reg;
                        end
                        else if (c_reg.func == OP_PREPEND)
                        begin
                            pv_we = 1'b1; pv_wa = head_reg; pv_wd = n_reg;
                            nx_we = 1'b1; nx_wa = n_reg;    nx_wd = head_reg;
                            head_next = n_reg;
                            if (cval_reg) cidx_next = cidx_reg + 1'b1;
                        end
                        else
                        begin
                            nx_we = 1'b1; nx_wa = tail_reg; nx_wd = n_reg;
                            pv_we = 1'b1; pv_wa = n_reg;    pv_wd = tail_reg;
                            tail_next = n_reg;
                        end
                    end
                    OP_INS_BEFORE:
                    begin
                        pv_we = 1'b1; pv_wa = cur_reg; pv_wd = n_reg;
                        nx_we = 1'b1; nx_wa = n_reg;   nx_wd = cur_reg;
                        cidx_next = cidx_reg + 1'b1;
                    end
                    OP_INS_AFTER:
                    begin
                        nx_we = 1'b1; nx_wa = cur_reg; nx_wd = n_reg;
                        pv_we = 1'b1; pv_wa = n_reg;   pv_wd = cur_reg;
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR:
                    begin
                        if (c_reg.func == OP_DEL_FRONT && cval_reg)
                        begin
                            if (cur_reg == head_reg)
                            begin
                                cval_next = 1'b0; cidx_next = '0;
                            end
                            else
                            begin
                                cidx_next = cidx_reg - 1'b1;
                            end
                        end
                        if (c_reg.func == OP_DEL_BACK && cval_reg && cur_reg == tail_reg)
                        begin
                            cval_next = 1'b0; cidx_next = '0;
                        end
                        if (c_reg.func == OP_DEL_CURSOR)
                        begin
                            cval_next = 1'b0; cidx_next = '0;
                        end
                        if (n_reg == head_reg && n_reg == tail_reg)
                        begin
                            head_next = '0; tail_next = '0;
                        end
                        else if (n_reg == head_reg)
                        begin
                            head_next = q_reg;
                        end
                        else if (n_reg == tail_reg)
                        begin
                            tail_next = p_reg;
                        end
                        else
                        begin
                            nx_we = 1'b1; nx_wa = p_reg; nx_wd = q_reg;
                            pv_we = 1'b1; pv_wa = q_reg; pv_wd = p_reg;
                        end
                        cnt_next = cnt_reg - 1'b1;
                    end
                    OP_MV_PREV:
                    begin
                        if (cval_reg && !empty_list)
                        begin
                            if (cur_reg == head_reg)
                            begin
                                cval_next = 1'b0; cidx_next = '0;
                            end
                            else
                            begin
                                cur_next = p_reg; cidx_next = cidx_reg - 1'b1;
                            end
                        end
                    end
                    OP_MV_NEXT:
                    begin
                        if (cval_reg && !empty_list)
                        begin
                            if (cur_reg == tail_reg)
                            begin
                                cval_next = 1'b0; cidx_next = '0;
                            end
                            else
                            begin
                                cur_next = q_reg; cidx_next = cidx_reg + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            EX_WR3:
            begin
                case (c_reg.func)
                    OP_INS_BEFORE:
                    begin
                        pv_we = 1'b1; pv_wa = n_reg; pv_wd = p_reg;
                        if (cur_reg == head_reg)
                        begin
                            head_next = n_reg;
                        end
                        else
                        begin
                            nx_we = 1'b1; nx_wa = p_reg; nx_wd = n_reg;
                        end
                    end
                    OP_INS_AFTER:
                    begin
                        nx_we = 1'b1; nx_wa = n_reg; nx_wd = q_reg;
                        if (cur_reg == tail_reg)
                        begin
                            tail_next = n_reg;
                        end
                        else
                        begin
                            pv_we = 1'b1; pv_wa = q_reg; pv_wd = n_reg;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR:
                    begin
                        // push removed node onto the free stack
                        nx_we = 1'b1; nx_wa = n_reg; nx_wd = fhead_reg;
                        fhead_next = n_reg;
                        fcnt_next  = fcnt_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            EX_RDOUT:
            begin
                case (rdo_reg)
                    2'd0:    vl_ra = cur_reg;
                    2'd1:    vl_ra = head_reg;
                    default: vl_ra = tail_reg;
                endcase
            end
            EX_WAITOUT:
            begin
                rdo_next = rdo_reg + 2'd1;
            end
            EX_REPORT:
            begin
                if (!ob_full_reg || res_take) ob_load = 1'b1;
            end
            default: ;
        endcase
    end

    assign ob_full_next = ob_load ? 1'b1 : (res_take ? 1'b0 : ob_full_reg);

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        sts_reg <= sts_next;
        n_reg <= n_next;
        p_reg <= p_next;
        q_reg <= q_next;
        if (st_reg == EX_WAITOUT && rdo_reg == 2'd0) cv_reg <= vl_ext;
        if (st_reg == EX_WAITOUT && rdo_reg == 2'd1) fv_reg <= vl_ext;
        if (st_reg == EX_WAITOUT && rdo_reg == 2'd2) bv_reg <= vl_ext;
        if (ob_load)
        begin
            ob_sts_reg <= sts_reg;
            ob_len_reg <= cnt_reg;
            ob_pos_reg <= cval_reg ? LenW'(cidx_reg) : '1;
            ob_cv_reg  <= cval_reg ? cv_reg : '0;
            ob_fv_reg  <= empty_list ? '0 : fv_reg;
            ob_bv_reg  <= empty_list ? '0 : bv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= EX_IDLE;
            head_reg <= '0; tail_reg <= '0; cur_reg <= '0;
            cval_reg <= 1'b0; cidx_reg <= '0; cnt_reg <= '0;
            fhead_reg <= '0; fcnt_reg <= '0; nu_reg <= '0;
            rdo_reg <= 2'd0;
            ob_full_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            head_reg <= head_next; tail_reg <= tail_next; cur_reg <= cur_next;
            cval_reg <= cval_next; cidx_reg <= cidx_next; cnt_reg <= cnt_next;
            fhead_reg <= fhead_next; fcnt_reg <= fcnt_next; nu_reg <= nu_next;
            rdo_reg <= rdo_next;
            ob_full_reg <= ob_full_next;
        end
    end

    assign res_valid    = ob_full_reg;
    assign status       = ob_sts_reg;
    assign list_length  = LenW'(ob_len_reg);
    assign cursor_pos   = ob_pos_reg;
    assign cursor_value = ob_cv_reg;
    assign front_value  = ob_fv_reg;
    assign back_value   = ob_bv_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(POOL_DEPTH))
        else $error("entry count beyond pool");
    a_cur_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !cval_reg)
        else $error("cursor valid on empty list");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cval_reg && st_reg == EX_IDLE) |-> cidx_reg < cnt_reg)
        else $error("cursor index beyond length");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == EX_IDLE) |-> (cnt_reg + fcnt_reg == nu_reg))
        else $error("pool accounting broken");
`endif

endmodule

/* hw/rtl/cursor_doubly_linked_list.sv */
// ============================================================================
// cursor_doubly_linked_list: doubly linked list with cursor
// Node pool with prev/next links; one result word per command word.
// ============================================================================
//  channel  handshake           payload
//  command  push / full         func, value_in
//  result   empty / pop         status, list_length, cursor_pos,
//                               cursor_value, front_value, back_value
//
//  Link edits and moves to prev/next run decide, a dependent link read,
//  three link write steps and then three value reads for the report;
//  clear, moves to front/back, read and refused commands go from decide
//  straight to the value reads.
//  A two-word command queue keeps accepting while the engine works, until it is full.
//  The result register holds one word; the engine waits when it is full.
//  Reset clears all pointers and counts; node RAMs need no clearing since
//  data read from nodes not on the list or free stack is never used.
module cursor_doubly_linked_list
    import cdll_pkg::*;
#(
    parameter int unsigned POOL_DEPTH  = PoolDepthDefault,
    parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [FuncW-1:0] func,
    input  logic [DataW-1:0] value_in,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       status,
    output logic [LenW-1:0]  list_length,
    output logic [LenW-1:0]  cursor_pos,
    output logic [DataW-1:0] cursor_value,
    output logic [DataW-1:0] front_value,
    output logic [DataW-1:0] back_value
);

    logic cmd_valid, cmd_take, res_valid;
    cmd_t cmd;

    cdll_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .func(func), .value_in(value_in),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    cdll_back #(.POOL_DEPTH(POOL_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
        .res_valid(res_valid), .res_take(pop),
        .status(status), .list_length(list_length), .cursor_pos(cursor_pos),
        .cursor_value(cursor_value), .front_value(front_value),
        .back_value(back_value)
    );

    assign empty = !res_valid;

`ifndef SYNTHESIS
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> status != 2'd3)
        else $error("bad status code");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(list_length))
        else $error("result dropped");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> list_length <= LenW'(POOL_DEPTH))
        else $error("length beyond pool");
`endif

endmodule
